// ----- hdl/sti_pkg.sv -----
// sti_pkg: shared constants, types and opcode/status codes for the sorted table
// no dependencies
package sti_pkg;
	localparam int CAPACITY     = 64;
	localparam int KEY_BITS     = 32;
	localparam int PAYLOAD_BITS = 32;
	localparam int IDX_BITS     = $clog2(CAPACITY);
	localparam int CNT_BITS     = $clog2(CAPACITY + 1);
	localparam int QUEUE_DEPTH  = 2;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_SEARCH = 2'd1;
	localparam logic [1:0] OP_DELETE = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_DUP     = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [1:0] ST_MISSING = 2'd3;

	typedef enum logic [1:0] {
		CMD_INSERT,
		CMD_SEARCH,
		CMD_DELETE,
		CMD_NONE
	} cmd_t;

	// classified request handed from front to back
	typedef struct packed {
		cmd_t                    cmd;
		logic [KEY_BITS-1:0]     key;
		logic [PAYLOAD_BITS-1:0] payload;
	} req_t;
endpackage

// ----- hdl/sti_front.sv -----
// sti_front: accepts request beats, classifies the opcode, queues requests
// depends on sti_pkg
module sti_front import sti_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [31:0] key,
	input  logic [31:0] payload_in,
	output logic        req_valid,
	input  logic        req_take,
	output req_t        req
);
	localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

	req_t                queue_q [QUEUE_DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_BITS:0]   level_q;
	logic                push, pop;
	req_t                incoming;

	// opcode decode
	always_comb begin
		incoming.key     = key[KEY_BITS-1:0];
		incoming.payload = payload_in[PAYLOAD_BITS-1:0];
		unique case (opcode)
			OP_INSERT: incoming.cmd = CMD_INSERT;
			OP_SEARCH: incoming.cmd = CMD_SEARCH;
			OP_DELETE: incoming.cmd = CMD_DELETE;
			default:   incoming.cmd = CMD_NONE;
		endcase
	end

	assign in_stall  = (level_q == (PTR_BITS+1)'(QUEUE_DEPTH));
	assign push      = in_valid && !in_stall;
	assign req_valid = (level_q != '0);
	assign pop       = req_valid && req_take;
	assign req       = queue_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) queue_q[wr_ptr_q] <= incoming;
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)      level_q <= level_q + 1'b1;
			else if (pop && !push) level_q <= level_q - 1'b1;
		end
	end
endmodule

// ----- hdl/sti_back.sv -----
// sti_back: scans and shifts the sorted table entry by entry, takes a new request only when idle, and holds the result
// depends on sti_pkg
module sti_back import sti_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_take,
	input  req_t        req,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [31:0] payload_out,
	output logic [6:0]  fill_count
);
	typedef enum logic [2:0] {
		S_IDLE, S_READ, S_CMP, S_UP_RD, S_UP_WR, S_DN_RD, S_DN_WR, S_DONE
	} state_t;

	logic [KEY_BITS-1:0]     key_mem [CAPACITY];
	logic [PAYLOAD_BITS-1:0] pay_mem [CAPACITY];

	state_t                  state_q;
	req_t                    req_q;
	logic [CNT_BITS-1:0]     count_q, pos_q, idx_q;
	logic [KEY_BITS-1:0]     rkey_q;
	logic [PAYLOAD_BITS-1:0] rpay_q;
	logic [1:0]              status_q;
	logic [PAYLOAD_BITS-1:0] pay_out_q;
	logic                    out_valid_q;

	// memory control
	logic                    we;
	logic [IDX_BITS-1:0]     waddr, raddr;
	logic [KEY_BITS-1:0]     wkey;
	logic [PAYLOAD_BITS-1:0] wpay;

	assign req_take    = (state_q == S_IDLE) && req_valid && !out_valid_q;
	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign payload_out = 32'(pay_out_q);
	assign fill_count  = 7'(count_q);

	// read address follows the walk index, one below it while reading for an upward shift
	always_comb begin
		raddr = idx_q[IDX_BITS-1:0];
		we    = 1'b0;
		waddr = idx_q[IDX_BITS-1:0];
		wkey  = rkey_q;
		wpay  = rpay_q;
		unique case (state_q)
			S_UP_RD: begin
				raddr = IDX_BITS'(idx_q - 1'b1);
			end
			S_UP_WR: begin
				we = 1'b1;
				if (idx_q == pos_q) begin
					wkey = req_q.key;
					wpay = req_q.payload;
				end
			end
			S_DN_WR: begin
				we    = 1'b1;
				waddr = IDX_BITS'(idx_q - 1'b1);
			end
			default: ;
		endcase
	end

	// table storage, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			key_mem[waddr] <= wkey;
			pay_mem[waddr] <= wpay;
		end
		rkey_q <= key_mem[raddr];
		rpay_q <= pay_mem[raddr];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			pos_q       <= '0;
			idx_q       <= '0;
			status_q    <= ST_OK;
			pay_out_q   <= '0;
			out_valid_q <= 1'b0;
			req_q       <= '0;
		end else begin
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (req_take) begin
						req_q   <= req;
						idx_q   <= '0;
						state_q <= S_READ;
					end
				end
				S_READ: begin
					// wait for the registered read of entry idx_q
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (idx_q < count_q && rkey_q < req_q.key) begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_READ;
					end else begin
						logic hit;
						hit = (idx_q < count_q) && (rkey_q == req_q.key);
						pos_q     <= idx_q;
						pay_out_q <= '0;
						status_q  <= ST_MISSING;
						state_q   <= S_DONE;
						case (req_q.cmd)
							CMD_INSERT: begin
								if (count_q == CNT_BITS'(CAPACITY)) status_q <= ST_FULL;
								else if (hit) status_q <= ST_DUP;
								else begin
									status_q <= ST_OK;
									idx_q    <= count_q;
									state_q  <= S_UP_RD;
								end
							end
							CMD_SEARCH: begin
								if (hit) begin
									status_q  <= ST_OK;
									pay_out_q <= rpay_q;
								end
							end
							CMD_DELETE: begin
								if (hit) begin
									status_q  <= ST_OK;
									pay_out_q <= rpay_q;
									idx_q     <= idx_q + 1'b1;
									state_q   <= S_DN_RD;
								end
							end
							default: ;
						endcase
					end
				end
				S_UP_RD: begin
					// read entry idx_q-1 to move into idx_q
					state_q <= S_UP_WR;
				end
				S_UP_WR: begin
					if (idx_q == pos_q) begin
						count_q <= count_q + 1'b1;
						state_q <= S_DONE;
					end else begin
						idx_q   <= idx_q - 1'b1;
						state_q <= S_UP_RD;
					end
				end
				S_DN_RD: begin
					if (idx_q >= count_q) begin
						count_q <= count_q - 1'b1;
						state_q <= S_DONE;
					end else state_q <= S_DN_WR;
				end
				S_DN_WR: begin
					idx_q   <= idx_q + 1'b1;
					state_q <= S_DN_RD;
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ----- hdl/sorted_table_insert_search_delete_top.sv -----
// channel   | valid     | stall     | beat fields
// request   | in_valid  | in_stall  | opcode, key, payload_in
// response  | out_valid | out_stall | status, payload_out, fill_count
// each request walks the table up to its search position; an insert or
// delete then shifts the later entries by one place, entry by entry, and
// an insert writes the new entry into its place. reset clears the count
// and handshakes, not the table.
// a two-deep queue lets requests be taken while the back part works.
// depends on sti_pkg, sti_front, sti_back
module sorted_table_insert_search_delete_top import sti_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [31:0] key,
	input  logic [31:0] payload_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [31:0] payload_out,
	output logic [6:0]  fill_count
);
	logic req_valid, req_take;
	req_t req;

	sti_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .opcode, .key, .payload_in,
		.req_valid, .req_take, .req
	);

	sti_back u_back (
		.clk, .arst_n, .req_valid, .req_take, .req,
		.out_valid, .out_stall, .status, .payload_out, .fill_count
	);

	// count never exceeds capacity
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_count <= 7'(CAPACITY)) else $error("fill count over capacity");

	// a failed request returns zero payload
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> payload_out == '0)
		else $error("payload on failed request");

	// held response status and fill count stay stable while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(fill_count))
		else $error("response changed under stall");
endmodule
